/* rtl/core/itp_pkg.sv */
`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_POW  = 8'h5E;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_NL   = 8'h0A;

    localparam logic signed [7:0] BAL_MAX = 8'sd127;
    localparam logic signed [7:0] BAL_MIN = -8'sd128;

    typedef enum logic [2:0] {
        OP_LPAR = 3'd0,
        OP_POW  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_ADD  = 3'd4,
        OP_SUB  = 3'd5
    } op_code_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } cell_op_t;

    typedef enum logic [1:0] {
        K_CLOSE,
        K_MULDIV,
        K_ADDSUB,
        K_NL
    } kind_t;

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    typedef struct packed {
        cell_op_t   op;
        logic [2:0] code;
    } stack_ctrl_t;

    function automatic logic [7:0] op_char(input logic [2:0] code);
        logic [7:0] ch;
        case (code)
            OP_LPAR: ch = CH_LPAR;
            OP_POW:  ch = CH_POW;
            OP_MUL:  ch = CH_MUL;
            OP_DIV:  ch = CH_DIV;
            OP_ADD:  ch = CH_ADD;
            OP_SUB:  ch = CH_SUB;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // true when the entry on top must go to the output before the request finishes
    function automatic logic pop_cond(input kind_t kind, input logic [2:0] code,
                                      input cnt_t cnt);
        logic ok;
        case (kind)
            K_CLOSE:  ok = (cnt > cnt_t'(1)) && (code != OP_LPAR);
            K_MULDIV: ok = (cnt != '0) &&
                           (code == OP_POW || code == OP_MUL || code == OP_DIV);
            K_ADDSUB: ok = (cnt != '0) && (code != OP_LPAR);
            K_NL:     ok = (cnt != '0);
            default:  ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

/* rtl/core/itp_cell.sv */
`timescale 1ns / 1ps

module itp_cell (
    input  logic               clk,
    input  itp_pkg::cell_op_t  op,
    input  logic [2:0]         above,
    input  logic [2:0]         below,
    output logic [2:0]         q
);

    logic [2:0] q_reg;
    logic [2:0] q_next;

    always_comb
    begin
        case (op)
            itp_pkg::CELL_PUSH: q_next = above;
            itp_pkg::CELL_POP:  q_next = below;
            default:            q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

/* rtl/core/itp_stack.sv */
`timescale 1ns / 1ps

module itp_stack (
    input  logic                 clk,
    input  itp_pkg::stack_ctrl_t ctrl,
    output logic [2:0]           top,
    output logic [2:0]           second
);

    logic [2:0] data [itp_pkg::STACK_DEPTH];

    // cell 0 is the top; a push shifts every entry one cell down, a pop one cell up
    for (genvar i = 0; i < itp_pkg::STACK_DEPTH; i++) begin : g_cell
        logic [2:0] above;
        logic [2:0] below;

        if (i == 0) begin : g_head
            assign above = ctrl.code;
        end else begin : g_mid_up
            assign above = data[i-1];
        end

        if (i == itp_pkg::STACK_DEPTH - 1) begin : g_tail
            assign below = data[i];
        end else begin : g_mid_dn
            assign below = data[i+1];
        end

        itp_cell u_cell (
            .clk   (clk),
            .op    (ctrl.op),
            .above (above),
            .below (below),
            .q     (data[i])
        );
    end

    assign top    = data[0];
    assign second = data[1];

endmodule

/* rtl/core/infix_to_postfix_converter_core.sv */
`timescale 1ns / 1ps

// Shunting-yard infix to postfix converter. One character per request on the
// input channel; postfix symbols leave on the output channel, and a newline
// flushes the operator stack and then gives an end marker with a
// parenthesis-balance flag and an overflow flag (a push onto a full stack is
// dropped). The operator stack is a chain of cells that shifts one entry per
// cycle, so the block pops at most one operator per cycle, and only while the
// output side is free. An operand, '(' or '^' is handled as it is accepted;
// ')', '*', '/', '+', '-' and a newline enter a pop state that pops operators
// to the output and takes no new character until it returns to idle.
module infix_to_postfix_converter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] symbol,
    output logic       line_end,
    output logic       balanced,
    output logic       overflowed,
    output logic       last_of_run
);

    itp_pkg::state_t state_reg, state_next;
    itp_pkg::kind_t  kind_reg, kind_next;
    logic [2:0]      pcode_reg, pcode_next;
    itp_pkg::cnt_t   count_reg, count_next;
    logic signed [7:0] bal_reg, bal_next;
    logic            ovf_reg, ovf_next;

    logic            out_valid_reg;
    logic [7:0]      symbol_reg;
    logic            line_end_reg, balanced_reg, overflowed_reg, last_reg;

    itp_pkg::stack_ctrl_t ctrl;
    logic [2:0]      top, second;

    logic            in_acc, out_free;
    logic            pop_ok, pop_ok_next;
    logic            emit;
    logic [7:0]      emit_sym;
    logic            emit_le, emit_bal, emit_ovf, emit_last;

    itp_stack u_stack (
        .clk    (clk),
        .ctrl   (ctrl),
        .top    (top),
        .second (second)
    );

    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == itp_pkg::S_IDLE) && out_free;
    assign in_acc      = in_valid && in_ready;
    assign pop_ok      = itp_pkg::pop_cond(kind_reg, top, count_reg);
    assign pop_ok_next = itp_pkg::pop_cond(kind_reg, second, count_reg - itp_pkg::cnt_t'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itp_pkg::S_IDLE:
            begin
                if (in_acc && (char_in inside {itp_pkg::CH_RPAR, itp_pkg::CH_MUL,
                        itp_pkg::CH_DIV, itp_pkg::CH_ADD, itp_pkg::CH_SUB,
                        itp_pkg::CH_NL}))
                begin
                    state_next = itp_pkg::S_POP;
                end
            end
            itp_pkg::S_POP:
            begin
                if (!pop_ok && (kind_reg != itp_pkg::K_NL || out_free))
                begin
                    state_next = itp_pkg::S_IDLE;
                end
            end
            default: state_next = itp_pkg::S_IDLE;
        endcase
    end

    // datapath control and results
    always_comb
    begin
        ctrl.op    = itp_pkg::CELL_HOLD;
        ctrl.code  = pcode_reg;
        count_next = count_reg;
        bal_next   = bal_reg;
        ovf_next   = ovf_reg;
        kind_next  = kind_reg;
        pcode_next = pcode_reg;
        emit       = 1'b0;
        emit_sym   = 8'h00;
        emit_le    = 1'b0;
        emit_bal   = 1'b0;
        emit_ovf   = 1'b0;
        emit_last  = 1'b0;

        case (state_reg)
            itp_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (char_in)
                        itp_pkg::CH_LPAR, itp_pkg::CH_POW:
                        begin
                            if (char_in == itp_pkg::CH_LPAR)
                            begin
                                ctrl.code = itp_pkg::OP_LPAR;
                                if (bal_reg != itp_pkg::BAL_MAX)
                                begin
                                    bal_next = bal_reg + 8'sd1;
                                end
                            end
                            else
                            begin
                                ctrl.code = itp_pkg::OP_POW;
                            end
                            if (count_reg == itp_pkg::cnt_t'(itp_pkg::STACK_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.op    = itp_pkg::CELL_PUSH;
                                count_next = count_reg + itp_pkg::cnt_t'(1);
                            end
                        end
                        itp_pkg::CH_RPAR:
                        begin
                            kind_next = itp_pkg::K_CLOSE;
                            if (bal_reg != itp_pkg::BAL_MIN)
                            begin
                                bal_next = bal_reg - 8'sd1;
                            end
                        end
                        itp_pkg::CH_MUL, itp_pkg::CH_DIV:
                        begin
                            kind_next  = itp_pkg::K_MULDIV;
                            pcode_next = (char_in == itp_pkg::CH_MUL) ?
                                         itp_pkg::OP_MUL : itp_pkg::OP_DIV;
                        end
                        itp_pkg::CH_ADD, itp_pkg::CH_SUB:
                        begin
                            kind_next  = itp_pkg::K_ADDSUB;
                            pcode_next = (char_in == itp_pkg::CH_ADD) ?
                                         itp_pkg::OP_ADD : itp_pkg::OP_SUB;
                        end
                        itp_pkg::CH_NL:
                        begin
                            kind_next = itp_pkg::K_NL;
                        end
                        default:
                        begin
                            // operand: pass straight through
                            emit      = 1'b1;
                            emit_sym  = char_in;
                            emit_last = 1'b1;
                        end
                    endcase
                end
            end
            itp_pkg::S_POP:
            begin
                if (pop_ok)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_sym   = itp_pkg::op_char(top);
                        emit_last  = !pop_ok_next && (kind_reg != itp_pkg::K_NL);
                        ctrl.op    = itp_pkg::CELL_POP;
                        count_next = count_reg - itp_pkg::cnt_t'(1);
                    end
                end
                else
                begin
                    case (kind_reg)
                        itp_pkg::K_CLOSE:
                        begin
                            // drop the matching '('
                            if (count_reg != '0 && top == itp_pkg::OP_LPAR)
                            begin
                                ctrl.op    = itp_pkg::CELL_POP;
                                count_next = count_reg - itp_pkg::cnt_t'(1);
                            end
                        end
                        itp_pkg::K_MULDIV, itp_pkg::K_ADDSUB:
                        begin
                            if (count_reg == itp_pkg::cnt_t'(itp_pkg::STACK_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.op    = itp_pkg::CELL_PUSH;
                                count_next = count_reg + itp_pkg::cnt_t'(1);
                            end
                        end
                        itp_pkg::K_NL:
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                emit_le    = 1'b1;
                                emit_bal   = (bal_reg == 8'sd0);
                                emit_ovf   = ovf_reg;
                                emit_last  = 1'b1;
                                count_next = '0;
                                bal_next   = 8'sd0;
                                ovf_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                            ctrl.op = itp_pkg::CELL_HOLD;
                        end
                    endcase
                end
            end
            default:
            begin
                ctrl.op = itp_pkg::CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itp_pkg::S_IDLE;
            kind_reg      <= itp_pkg::K_NL;
            count_reg     <= '0;
            bal_reg       <= 8'sd0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            bal_reg   <= bal_next;
            ovf_reg   <= ovf_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pcode_reg <= pcode_next;
        if (emit)
        begin
            symbol_reg     <= emit_sym;
            line_end_reg   <= emit_le;
            balanced_reg   <= emit_bal;
            overflowed_reg <= emit_ovf;
            last_reg       <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol      = symbol_reg;
    assign line_end    = line_end_reg;
    assign balanced    = balanced_reg;
    assign overflowed  = overflowed_reg;
    assign last_of_run = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= itp_pkg::cnt_t'(itp_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == itp_pkg::CELL_POP |-> count_reg != '0)
        else $error("pop from empty stack");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == itp_pkg::CELL_PUSH
            |-> count_reg != itp_pkg::cnt_t'(itp_pkg::STACK_DEPTH))
        else $error("push onto full stack");

    a_marker_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_le) |=> (count_reg == '0 && bal_reg == 8'sd0 && !ovf_reg
            && state_reg == itp_pkg::S_IDLE))
        else $error("line state not cleared after end marker");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == itp_pkg::S_POP |-> !in_ready)
        else $error("input taken while popping");

endmodule

/* tb/itp_postfix_checker.sv */
`timescale 1ns / 1ps

module itp_postfix_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] symbol,
    input  logic       line_end,
    input  logic       balanced,
    input  logic       overflowed,
    input  logic       last_of_run,
    output int         mismatches,
    output int         pending
);

    typedef struct packed {
        logic [7:0] symbol;
        logic       line_end;
        logic       balanced;
        logic       overflowed;
        logic       last_of_run;
    } postfix_sym_t;

    postfix_sym_t         symbols_due[$];
    itp_pkg::op_code_t    op_stack[itp_pkg::STACK_DEPTH];
    int                   op_depth;
    int                   paren_level;
    logic                 push_lost;
    int                   run_len;

    function automatic logic [7:0] glyph_of(input itp_pkg::op_code_t code);
        case (code)
            itp_pkg::OP_LPAR: return itp_pkg::CH_LPAR;
            itp_pkg::OP_POW:  return itp_pkg::CH_POW;
            itp_pkg::OP_MUL:  return itp_pkg::CH_MUL;
            itp_pkg::OP_DIV:  return itp_pkg::CH_DIV;
            itp_pkg::OP_ADD:  return itp_pkg::CH_ADD;
            itp_pkg::OP_SUB:  return itp_pkg::CH_SUB;
            default:          return 8'h00;
        endcase
    endfunction

    task automatic note_symbol(input logic [7:0] sym, input logic le, input logic bal,
                               input logic ovf);
        postfix_sym_t s;
        s.symbol      = sym;
        s.line_end    = le;
        s.balanced    = bal;
        s.overflowed  = ovf;
        s.last_of_run = 1'b0;
        symbols_due.push_back(s);
        run_len++;
    endtask

    task automatic pop_to_output();
        op_depth--;
        note_symbol(glyph_of(op_stack[op_depth]), 1'b0, 1'b0, 1'b0);
    endtask

    task automatic push_op(input itp_pkg::op_code_t code);
        // drop the push on a full stack, but remember it until the line ends
        if (op_depth >= itp_pkg::STACK_DEPTH)
            push_lost = 1'b1;
        else
        begin
            op_stack[op_depth] = code;
            op_depth++;
        end
    endtask

    task automatic shift_level(input int delta);
        paren_level = paren_level + delta;
        if (paren_level > int'(itp_pkg::BAL_MAX))
            paren_level = int'(itp_pkg::BAL_MAX);
        if (paren_level < int'(itp_pkg::BAL_MIN))
            paren_level = int'(itp_pkg::BAL_MIN);
    endtask

    task automatic predict_postfix(input logic [7:0] ch);
        postfix_sym_t tail;
        run_len = 0;
        case (ch)
            itp_pkg::CH_LPAR:
            begin
                shift_level(1);
                push_op(itp_pkg::OP_LPAR);
            end
            itp_pkg::CH_RPAR:
            begin
                shift_level(-1);
                // a lone operator left at the bottom stays put
                while (op_depth > 1 && op_stack[op_depth-1] != itp_pkg::OP_LPAR)
                    pop_to_output();
                if (op_depth > 0 && op_stack[op_depth-1] == itp_pkg::OP_LPAR)
                    op_depth--;
            end
            itp_pkg::CH_POW:
                push_op(itp_pkg::OP_POW);
            itp_pkg::CH_MUL, itp_pkg::CH_DIV:
            begin
                while (op_depth > 0 && (op_stack[op_depth-1] == itp_pkg::OP_POW ||
                       op_stack[op_depth-1] == itp_pkg::OP_MUL ||
                       op_stack[op_depth-1] == itp_pkg::OP_DIV))
                    pop_to_output();
                push_op(ch == itp_pkg::CH_MUL ? itp_pkg::OP_MUL : itp_pkg::OP_DIV);
            end
            itp_pkg::CH_ADD, itp_pkg::CH_SUB:
            begin
                while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::OP_LPAR)
                    pop_to_output();
                push_op(ch == itp_pkg::CH_ADD ? itp_pkg::OP_ADD : itp_pkg::OP_SUB);
            end
            itp_pkg::CH_NL:
            begin
                while (op_depth > 0)
                    pop_to_output();
                note_symbol(8'h00, 1'b1, paren_level == 0, push_lost);
                op_depth    = 0;
                paren_level = 0;
                push_lost   = 1'b0;
            end
            default:
                note_symbol(ch, 1'b0, 1'b0, 1'b0);
        endcase
        if (run_len > 0)
        begin
            tail = symbols_due.pop_back();
            tail.last_of_run = 1'b1;
            symbols_due.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("%0t itp check: %s got %h expected %h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        postfix_sym_t want;
        if (!rst_n)
        begin
            symbols_due.delete();
            op_depth    = 0;
            paren_level = 0;
            push_lost   = 1'b0;
            mismatches  = 0;
        end
        else
        begin
            // take the request first so a same-edge result still finds it queued
            if (in_valid && in_ready)
                predict_postfix(char_in);
            if (out_valid && out_ready)
            begin
                if (symbols_due.size() == 0)
                    report_mismatch("result with nothing expected, symbol", symbol, 8'h00);
                else
                begin
                    want = symbols_due.pop_front();
                    if (symbol !== want.symbol)
                        report_mismatch("symbol", symbol, want.symbol);
                    if (line_end !== want.line_end)
                        report_mismatch("line_end", 8'(line_end), 8'(want.line_end));
                    if (balanced !== want.balanced)
                        report_mismatch("balanced", 8'(balanced), 8'(want.balanced));
                    if (overflowed !== want.overflowed)
                        report_mismatch("overflowed", 8'(overflowed),
                                        8'(want.overflowed));
                    if (last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 8'(last_of_run),
                                        8'(want.last_of_run));
                end
            end
        end
        pending = symbols_due.size();
    end

endmodule

/* tb/tb_infix_to_postfix_converter_core.sv */
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_core;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 120;
    localparam int DRAIN_CYCLES = 64;

    typedef enum logic [2:0] {
        PACE_FREE,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH,
        PACE_HOLD
    } pace_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] symbol;
    logic       line_end;
    logic       balanced;
    logic       overflowed;
    logic       last_of_run;

    int         mismatches;
    int         pending;
    int         cycles;
    int         sent;
    pace_t      pace;
    logic       held;
    logic [7:0] line_buf[$];

    infix_to_postfix_converter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol      (symbol),
        .line_end    (line_end),
        .balanced    (balanced),
        .overflowed  (overflowed),
        .last_of_run (last_of_run)
    );

    itp_postfix_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol      (symbol),
        .line_end    (line_end),
        .balanced    (balanced),
        .overflowed  (overflowed),
        .last_of_run (last_of_run),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_infix_to_postfix_converter_core: FAIL");
            $finish;
        end
    end

    // receiver: random stalls per pace, plus one long hold-off to back up the block
    initial
    begin : receiver
        int stall_pct;
        out_ready = 1'b0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pace == PACE_HOLD && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall_pct = (pace == PACE_RECV_STALLS) ? 84 : (pace == PACE_BOTH) ? 29 : 0;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_char(input logic [7:0] ch);
        int gap_pct;
        gap_pct = (pace == PACE_SEND_GAPS) ? 84 : (pace == PACE_BOTH) ? 29 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= ch;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    function automatic logic [7:0] operand_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == itp_pkg::CH_LPAR || b == itp_pkg::CH_RPAR || b == itp_pkg::CH_POW ||
               b == itp_pkg::CH_MUL || b == itp_pkg::CH_DIV || b == itp_pkg::CH_ADD ||
               b == itp_pkg::CH_SUB || b == itp_pkg::CH_NL);
        return b;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 4))
            0:       return itp_pkg::CH_POW;
            1:       return itp_pkg::CH_MUL;
            2:       return itp_pkg::CH_DIV;
            3:       return itp_pkg::CH_ADD;
            default: return itp_pkg::CH_SUB;
        endcase
    endfunction

    // well-formed infix line with random nesting
    task automatic build_expression();
        int depth;
        int terms;
        depth = 0;
        terms = $urandom_range(1, 8);
        for (int i = 0; i < terms; i++)
        begin
            if (i > 0)
                line_buf.push_back(pick_operator());
            while ($urandom_range(0, 3) == 0 && depth < 6)
            begin
                line_buf.push_back(itp_pkg::CH_LPAR);
                depth++;
            end
            line_buf.push_back(operand_byte());
            while (depth > 0 && $urandom_range(0, 2) == 0)
            begin
                line_buf.push_back(itp_pkg::CH_RPAR);
                depth--;
            end
        end
        repeat (depth) line_buf.push_back(itp_pkg::CH_RPAR);
        line_buf.push_back(itp_pkg::CH_NL);
    endtask

    // long right-associative chain: deep stack, often past full
    task automatic build_power_chain();
        int links;
        links = $urandom_range(20, 40);
        line_buf.push_back(operand_byte());
        repeat (links)
        begin
            line_buf.push_back(itp_pkg::CH_POW);
            line_buf.push_back(operand_byte());
        end
        line_buf.push_back(itp_pkg::CH_NL);
    endtask

    // broken lines: tokens in any order, sometimes running into the next line
    task automatic build_noise();
        int len;
        len = $urandom_range(1, 10);
        repeat (len)
        begin
            case ($urandom_range(0, 3))
                0:       line_buf.push_back(operand_byte());
                1:       line_buf.push_back(pick_operator());
                2:       line_buf.push_back(itp_pkg::CH_LPAR);
                default: line_buf.push_back(itp_pkg::CH_RPAR);
            endcase
        end
        if ($urandom_range(0, 1) == 0)
            line_buf.push_back(itp_pkg::CH_NL);
    endtask

    initial
    begin : stimulus
        int target;
        int roll;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        char_in  = 8'h00;
        pace     = PACE_FREE;
        cycles   = 0;
        sent     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // close on empty stack; close leaving a lone '+'; byte extremes with '^', '*',
        // '/', '-' and precedence; parenthesized group
        line_buf = '{itp_pkg::CH_RPAR, itp_pkg::CH_NL,
                     8'h61, itp_pkg::CH_ADD, 8'h62, itp_pkg::CH_RPAR, itp_pkg::CH_NL,
                     8'h00, itp_pkg::CH_POW, 8'hFF, itp_pkg::CH_POW, 8'h63,
                     itp_pkg::CH_MUL, 8'h64, itp_pkg::CH_DIV,
                     8'h65, itp_pkg::CH_SUB, 8'h66, itp_pkg::CH_NL,
                     itp_pkg::CH_LPAR, 8'h78, itp_pkg::CH_SUB, 8'h79, itp_pkg::CH_RPAR,
                     itp_pkg::CH_NL};
        foreach (line_buf[i])
            send_char(line_buf[i]);

        // overflow the stack with opens, leaving the line unbalanced
        pace = PACE_BOTH;
        repeat (itp_pkg::STACK_DEPTH + 1) send_char(itp_pkg::CH_LPAR);
        send_char(itp_pkg::CH_NL);

        for (int p = 0; p < 5; p++)
        begin
            pace   = pace_t'(p);
            target = sent + RANDOM_ITEMS / 5;
            while (sent < target)
            begin
                line_buf.delete();
                roll = $urandom_range(0, 9);
                if (roll < 7)
                    build_expression();
                else if (roll == 7)
                    build_power_chain();
                else
                    build_noise();
                foreach (line_buf[i])
                    send_char(line_buf[i]);
            end
        end

        pace = PACE_FREE;
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_infix_to_postfix_converter_core: PASS");
        else
            $display("tb_infix_to_postfix_converter_core: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/itp_pkg.sv
rtl/core/itp_cell.sv
rtl/core/itp_stack.sv
rtl/core/infix_to_postfix_converter_core.sv
tb/itp_postfix_checker.sv
tb/tb_infix_to_postfix_converter_core.sv
